@@ sv/otc_pkg.sv @@
`default_nettype none
package otc_pkg;

   localparam int KIND_COUNT = 51;
   localparam int KIND_BITS = 6;
   localparam int MAX_TOKEN = 7;
   localparam int LOOKAHEAD_DEF = 7;
   localparam int COUNT_BITS_DEF = 32;
   localparam int OUT_COUNT_BITS = 32;
   localparam int DISTINCT_BITS = 6;

   typedef enum logic [1:0] {
      MODE_CPP = 2'd0,
      MODE_JS  = 2'd1,
      MODE_PY  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COUNT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [55:0] text;
   } token_type;

   function automatic token_type kind_token(input logic [KIND_BITS-1:0] k);
      token_type t;
      t.text = '0;
      t.len = 3'd1;
      case (k)
         6'd0:  begin t.text = 56'("=="); t.len = 3'd2; end
         6'd1:  begin t.text = 56'("!="); t.len = 3'd2; end
         6'd2:  begin t.text = 56'("<="); t.len = 3'd2; end
         6'd3:  begin t.text = 56'(">="); t.len = 3'd2; end
         6'd4:  begin t.text = 56'("+="); t.len = 3'd2; end
         6'd5:  begin t.text = 56'("-="); t.len = 3'd2; end
         6'd6:  begin t.text = 56'("*="); t.len = 3'd2; end
         6'd7:  begin t.text = 56'("/="); t.len = 3'd2; end
         6'd8:  begin t.text = 56'("%="); t.len = 3'd2; end
         6'd9:  begin t.text = 56'("<<="); t.len = 3'd3; end
         6'd10: begin t.text = 56'(">>="); t.len = 3'd3; end
         6'd11: begin t.text = 56'("&="); t.len = 3'd2; end
         6'd12: begin t.text = 56'("^="); t.len = 3'd2; end
         6'd13: begin t.text = 56'("|="); t.len = 3'd2; end
         6'd14: begin t.text = 56'("++"); t.len = 3'd2; end
         6'd15: begin t.text = 56'("--"); t.len = 3'd2; end
         6'd16: begin t.text = 56'("&&"); t.len = 3'd2; end
         6'd17: begin t.text = 56'("||"); t.len = 3'd2; end
         6'd18: begin t.text = 56'("|"); t.len = 3'd1; end
         6'd19: begin t.text = 56'("<<"); t.len = 3'd2; end
         6'd20: begin t.text = 56'("("); t.len = 3'd1; end
         6'd21: begin t.text = 56'(")"); t.len = 3'd1; end
         6'd22: begin t.text = 56'(">>"); t.len = 3'd2; end
         6'd23: begin t.text = 56'("->"); t.len = 3'd2; end
         6'd24: begin t.text = 56'("="); t.len = 3'd1; end
         6'd25: begin t.text = 56'("-"); t.len = 3'd1; end
         6'd26: begin t.text = 56'("*"); t.len = 3'd1; end
         6'd27: begin t.text = 56'("/"); t.len = 3'd1; end
         6'd28: begin t.text = 56'("%"); t.len = 3'd1; end
         6'd29: begin t.text = 56'("<"); t.len = 3'd1; end
         6'd30: begin t.text = 56'(">"); t.len = 3'd1; end
         6'd31: begin t.text = 56'("&"); t.len = 3'd1; end
         6'd32: begin t.text = 56'("^"); t.len = 3'd1; end
         6'd33: begin t.text = 56'("{"); t.len = 3'd1; end
         6'd34: begin t.text = 56'("int"); t.len = 3'd3; end
         6'd35: begin t.text = 56'("char"); t.len = 3'd4; end
         6'd36: begin t.text = 56'("string"); t.len = 3'd6; end
         6'd37: begin t.text = 56'("bool"); t.len = 3'd4; end
         6'd38: begin t.text = 56'("float"); t.len = 3'd5; end
         6'd39: begin t.text = 56'("double"); t.len = 3'd6; end
         6'd40: begin t.text = 56'("if"); t.len = 3'd2; end
         6'd41: begin t.text = 56'("for"); t.len = 3'd3; end
         6'd42: begin t.text = 56'("do"); t.len = 3'd2; end
         6'd43: begin t.text = 56'("return"); t.len = 3'd6; end
         6'd44: begin t.text = 56'("~"); t.len = 3'd1; end
         6'd45: begin t.text = 56'("+"); t.len = 3'd1; end
         6'd46: begin t.text = 56'("!"); t.len = 3'd1; end
         6'd47: begin t.text = 56'("try"); t.len = 3'd3; end
         6'd48: begin t.text = 56'("catch"); t.len = 3'd5; end
         6'd49: begin t.text = 56'("while"); t.len = 3'd5; end
         6'd50: begin t.text = 56'("forEach"); t.len = 3'd7; end
         default: begin t.text = '0; t.len = 3'd1; end
      endcase
      return t;
   endfunction

   function automatic logic [KIND_BITS-1:0] order_count(input mode_type m);
      logic [KIND_BITS-1:0] n;
      unique case (m)
         MODE_CPP: n = 6'd47;
         MODE_JS:  n = 6'd44;
         MODE_PY:  n = 6'd43;
         default:  n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic [KIND_BITS-1:0] order_kind(input mode_type m,
                                                       input logic [KIND_BITS-1:0] i);
      logic [KIND_BITS-1:0] k;
      k = i;
      if (i >= 6'd34) begin
         if (m == MODE_JS) begin
            case (i)
               6'd34: k = 6'd40;
               6'd35: k = 6'd41;
               6'd36: k = 6'd42;
               6'd37: k = 6'd47;
               6'd38: k = 6'd50;
               6'd39: k = 6'd48;
               6'd40: k = 6'd49;
               6'd41: k = 6'd43;
               6'd42: k = 6'd44;
               6'd43: k = 6'd46;
               default: k = i;
            endcase
         end else if (m == MODE_PY) begin
            case (i)
               6'd34: k = 6'd40;
               6'd35: k = 6'd41;
               6'd36: k = 6'd42;
               6'd37: k = 6'd47;
               6'd38: k = 6'd48;
               6'd39: k = 6'd49;
               6'd40: k = 6'd43;
               6'd41: k = 6'd44;
               6'd42: k = 6'd46;
               default: k = i;
            endcase
         end
      end
      return k;
   endfunction

endpackage
`default_nettype wire

@@ sv/operator_token_counter.sv @@
`default_nettype none
// Operator token counter. Byte words are taken while idle; once one fills the
// lookahead window, the front position is resolved by one shared matcher that
// tries one list alternative per cycle, through the alternatives of the selected
// language, and drops one byte if none of them matches. An end-of-text word
// resolves every remaining window position the same way, then counts the seen-kind
// bitmap one bit per cycle before the result word is offered. req_stall stays
// high while busy; a pending result blocks byte words only while a newer one waits.
module operator_token_counter #(
   parameter int LOOKAHEAD_BYTES = otc_pkg::LOOKAHEAD_DEF,
   parameter int COUNT_BITS = otc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [1:0]                           csr_wr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_char_code,
   input  wire logic                                 req_end_of_text,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [otc_pkg::OUT_COUNT_BITS-1:0]        rsp_occurrence_count,
   output logic [otc_pkg::DISTINCT_BITS-1:0]         rsp_distinct_count
);

   localparam int FILL_BITS = $clog2(LOOKAHEAD_BYTES + 1);
   localparam int IDX_BITS = $clog2(LOOKAHEAD_BYTES);
   localparam int KB = otc_pkg::KIND_BITS;

   otc_pkg::state_type state_ff, state_in;
   otc_pkg::mode_type  mode_ff;
   logic [7:0]            win_ff [LOOKAHEAD_BYTES];
   logic [7:0]            win_in [LOOKAHEAD_BYTES];
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [otc_pkg::KIND_COUNT-1:0] seen_ff, seen_in;
   logic [KB-1:0]         idx_ff, idx_in;
   logic                  flush_ff, flush_in;
   logic [otc_pkg::DISTINCT_BITS-1:0] dist_ff, dist_in;
   logic                  rsp_valid_ff;
   logic [otc_pkg::OUT_COUNT_BITS-1:0] rsp_occ_ff;
   logic [otc_pkg::DISTINCT_BITS-1:0]  rsp_dist_ff;

   logic [LOOKAHEAD_BYTES*8-1:0] win_flat;
   logic [KB-1:0] kind;
   logic [KB-1:0] n_alt;
   logic          hit;
   logic [2:0]    tok_len;
   logic [2:0]    drop;
   logic          do_drop;
   logic [FILL_BITS-1:0] fill_after;
   logic          accept;
   logic          load_rsp;
   logic          sat;

   always_comb begin
      for (int j = 0; j < LOOKAHEAD_BYTES; j++) begin
         win_flat[8*j +: 8] = win_ff[j];
      end
   end

   assign n_alt = otc_pkg::order_count(mode_ff);
   assign kind = otc_pkg::order_kind(mode_ff, idx_ff);

   otc_matcher #(
      .LOOKAHEAD_BYTES(LOOKAHEAD_BYTES),
      .FILL_BITS(FILL_BITS)
   ) u_matcher (
      .window(win_flat),
      .fill(fill_ff),
      .kind(kind),
      .hit(hit),
      .len(tok_len)
   );

   assign accept = req_valid && !req_stall;
   assign sat = 64'(total_ff) > 64'h0000_0000_FFFF_FFFF;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         otc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_end_of_text) begin
                  state_in = (fill_ff != '0) ? otc_pkg::ST_SCAN : otc_pkg::ST_COUNT;
               end else if (fill_ff == FILL_BITS'(LOOKAHEAD_BYTES - 1)) begin
                  state_in = otc_pkg::ST_SCAN;
               end
            end
         end
         otc_pkg::ST_SCAN: begin
            if (do_drop) begin
               if (flush_ff) begin
                  state_in = (fill_after != '0) ? otc_pkg::ST_SCAN : otc_pkg::ST_COUNT;
               end else begin
                  state_in = otc_pkg::ST_IDLE;
               end
            end
         end
         otc_pkg::ST_COUNT: begin
            if (idx_ff == KB'(otc_pkg::KIND_COUNT - 1)) begin
               state_in = otc_pkg::ST_DONE;
            end
         end
         otc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = otc_pkg::ST_IDLE;
            end
         end
         default: state_in = otc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != otc_pkg::ST_IDLE);
      load_rsp = (state_ff == otc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      do_drop = 1'b0;
      drop = 3'd1;
      if (state_ff == otc_pkg::ST_SCAN) begin
         if (idx_ff >= n_alt) begin
            do_drop = 1'b1;
         end else if (hit) begin
            do_drop = 1'b1;
            drop = tok_len;
         end
      end
      fill_after = fill_ff - FILL_BITS'(drop);
   end

   always_comb begin
      win_in = win_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      seen_in = seen_ff;
      idx_in = idx_ff;
      flush_in = flush_ff;
      dist_in = dist_ff;
      unique case (state_ff)
         otc_pkg::ST_IDLE: begin
            idx_in = '0;
            dist_in = '0;
            if (accept) begin
               flush_in = req_end_of_text;
               if (!req_end_of_text) begin
                  win_in[fill_ff[IDX_BITS-1:0]] = req_char_code;
                  fill_in = fill_ff + FILL_BITS'(1);
               end
            end
         end
         otc_pkg::ST_SCAN: begin
            if (do_drop) begin
               idx_in = '0;
               fill_in = fill_after;
               for (int j = 0; j < LOOKAHEAD_BYTES; j++) begin
                  for (int d = 1; d <= otc_pkg::MAX_TOKEN; d++) begin
                     if (j + d < LOOKAHEAD_BYTES && drop == 3'(d)) begin
                        win_in[j] = win_ff[j + d];
                     end
                  end
               end
               if (idx_ff < n_alt) begin
                  if (total_ff != '1) begin
                     total_in = total_ff + COUNT_BITS'(1);
                  end
                  seen_in[kind] = 1'b1;
               end
            end else begin
               idx_in = idx_ff + KB'(1);
            end
         end
         otc_pkg::ST_COUNT: begin
            dist_in = dist_ff + otc_pkg::DISTINCT_BITS'(seen_ff[idx_ff]);
            idx_in = idx_ff + KB'(1);
         end
         otc_pkg::ST_DONE: begin
            if (load_rsp) begin
               fill_in = '0;
               total_in = '0;
               seen_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otc_pkg::ST_IDLE;
         mode_ff <= otc_pkg::MODE_CPP;
         fill_ff <= '0;
         total_ff <= '0;
         seen_ff <= '0;
         idx_ff <= '0;
         flush_ff <= 1'b0;
         dist_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         seen_ff <= seen_in;
         idx_ff <= idx_in;
         flush_ff <= flush_in;
         dist_ff <= dist_in;
         if (csr_wr_en) begin
            mode_ff <= otc_pkg::mode_type'(csr_wr_data);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (load_rsp) begin
         rsp_occ_ff <= sat ? '1 : otc_pkg::OUT_COUNT_BITS'(total_ff);
         rsp_dist_ff <= dist_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_occurrence_count = rsp_occ_ff;
   assign rsp_distinct_count = rsp_dist_ff;

endmodule
`default_nettype wire

@@ sv/otc_matcher.sv @@
`default_nettype none
module otc_matcher #(
   parameter int LOOKAHEAD_BYTES = otc_pkg::LOOKAHEAD_DEF,
   parameter int FILL_BITS = $clog2(LOOKAHEAD_BYTES + 1)
) (
   input  wire logic [LOOKAHEAD_BYTES*8-1:0]   window,
   input  wire logic [FILL_BITS-1:0]           fill,
   input  wire logic [otc_pkg::KIND_BITS-1:0]  kind,
   output logic                                hit,
   output logic [2:0]                          len
);

   otc_pkg::token_type tok;
   logic [55:0] shifted;

   always_comb begin
      tok = otc_pkg::kind_token(kind);
      len = tok.len;
      hit = (FILL_BITS'(tok.len) <= fill);
      shifted = '0;
      for (int p = 0; p < otc_pkg::MAX_TOKEN; p++) begin
         if (3'(p) < tok.len) begin
            shifted = tok.text >> (6'(tok.len - 3'(p) - 3'd1) * 6'd8);
            if (window[8*p +: 8] != shifted[7:0]) begin
               hit = 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire
